@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression holds at every edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// consequent holds at the same edge as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// consequent holds at the edge following the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/bbc_pkg.sv @@
// ---------------------------------------------------------------------------
// bbc_pkg
// types, byte codes and bracket decode for the bracket balance checker
// ---------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

  typedef logic [7:0]  char_t;
  typedef logic [15:0] bpos_t;
  typedef logic [1:0]  kind_t;

  localparam kind_t KIND_PAREN  = 2'd0;
  localparam kind_t KIND_BRACE  = 2'd1;
  localparam kind_t KIND_SQUARE = 2'd2;
  localparam kind_t KIND_NONE   = 2'd3;

  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;
  localparam char_t CH_LSQUARE = 8'h5B;
  localparam char_t CH_RSQUARE = 8'h5D;
  localparam char_t CH_SPACE  = 8'h20;

  function automatic kind_t open_kind(input char_t c);
    case (c)
      CH_LPAREN:  open_kind = KIND_PAREN;
      CH_LBRACE:  open_kind = KIND_BRACE;
      CH_LSQUARE: open_kind = KIND_SQUARE;
      default:    open_kind = KIND_NONE;
    endcase
  endfunction

  function automatic kind_t close_kind(input char_t c);
    case (c)
      CH_RPAREN:  close_kind = KIND_PAREN;
      CH_RBRACE:  close_kind = KIND_BRACE;
      CH_RSQUARE: close_kind = KIND_SQUARE;
      default:    close_kind = KIND_NONE;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ rtl/bbc_channels.sv @@
// ---------------------------------------------------------------------------
// bbc channels
// valid/ready interfaces for the byte stream and the result stream
// ---------------------------------------------------------------------------
`default_nettype none

interface bbc_in_if;
  logic            valid;
  logic            ready;
  bbc_pkg::char_t  char_code;
  logic            last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface bbc_out_if;
  logic            valid;
  logic            ready;
  logic            status;
  bbc_pkg::char_t  bad_char;
  bbc_pkg::bpos_t  bad_position;

  modport source (output valid, output status, output bad_char, output bad_position,
                  input ready);
  modport sink   (input valid, input status, input bad_char, input bad_position,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/bbc_stack_ram.sv @@
// ---------------------------------------------------------------------------
// bbc_stack_ram
// one write, one read port stack memory, registered read, write-first bypass
// ---------------------------------------------------------------------------
`default_nettype none

module bbc_stack_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire bbc_pkg::kind_t      wr_data,
  input  wire logic [AW-1:0]       rd_addr,
  output bbc_pkg::kind_t           rd_data
);

  bbc_pkg::kind_t mem [DEPTH];
  bbc_pkg::kind_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // same-address write is forwarded so the read sees the new entry
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/bracket_balance_checker.sv @@
// ---------------------------------------------------------------------------
// bracket_balance_checker
// streaming bracket balance check over a byte string, one byte per cycle
// ---------------------------------------------------------------------------
// Bytes arrive one per transaction on in_ch, last_char marking the end of a
// string. The block tracks (, { and [ on a stack and pops on ), } and ]. The
// first closing byte that pops an empty stack or the wrong kind yields one
// result transaction with status 1, the byte and its position (counted from
// zero, every byte counted, low 16 bits); the rest of the string is skipped.
// A string with no mismatch yields status 0 with zero fields on its last
// byte. Brackets left open are not reported and a push onto a full stack is
// dropped. Throughput is one byte per cycle: the top entry sits in a
// register, the stack memory is read one entry below it every cycle with a
// registered read and same-address forwarding, so push and pop both go
// back to back. The only stall is a result held in the output register
// while out_ch.ready is low. No clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker #(
  parameter int STACK_DEPTH = 64,
  parameter int MAX_LENGTH  = 65536
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bbc_in_if.sink     in_ch,
  bbc_out_if.source  out_ch
);

  // stack address and count widths
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  // position counter width and wrap point
  localparam int PW = $clog2(MAX_LENGTH);
  localparam logic [PW-1:0] POS_LAST = PW'(MAX_LENGTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

  // control state
  logic [CW-1:0]  count_r, count_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic           err_r, err_nxt;
  logic           out_valid_r, out_valid_nxt;
  // payload
  bbc_pkg::kind_t top_r, top_nxt;
  logic           out_status_r;
  bbc_pkg::char_t out_char_r;
  bbc_pkg::bpos_t out_pos_r;

  logic           in_acc;
  logic           active;
  bbc_pkg::kind_t ok_kind, ck_kind;
  logic           do_push, do_close, do_pop, bad;
  logic           emit;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [CW-1:0]  raddr_full;
  bbc_pkg::kind_t below_top;
  logic [PW+15:0] pos_wide;

  // accept while the result register is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // byte decode, skipped after a latched error and for spaces
  assign active  = !err_r && (in_ch.char_code != bbc_pkg::CH_SPACE);
  assign ok_kind = bbc_pkg::open_kind(in_ch.char_code);
  assign ck_kind = bbc_pkg::close_kind(in_ch.char_code);

  assign do_push  = in_acc && active && (ok_kind != bbc_pkg::KIND_NONE)
                    && (count_r != CNT_FULL);
  assign do_close = in_acc && active && (ck_kind != bbc_pkg::KIND_NONE);
  // empty-stack close is a mismatch, otherwise top kind must agree
  assign do_pop   = do_close && (count_r != '0);
  assign bad      = do_close && ((count_r == '0) || (top_r != ck_kind));
  assign emit     = bad || (in_acc && in_ch.last_char && !err_r);

  // a push spills the old top into the memory at count-1
  assign ram_we    = do_push && (count_r != '0);
  assign ram_waddr = AW'(count_r - CW'(1));
  // keep the entry below the next top loaded for a pop next cycle
  assign raddr_full = count_nxt - CW'(2);
  assign ram_raddr  = raddr_full[AW-1:0];

  bbc_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (top_r),
    .rd_addr (ram_raddr),
    .rd_data (below_top)
  );

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    err_nxt   = err_r;
    pos_nxt   = pos_r;
    if (do_push) begin
      count_nxt = count_r + CW'(1);
      top_nxt   = ok_kind;
    end else if (do_pop) begin
      count_nxt = count_r - CW'(1);
      // stale when the stack empties, never compared then
      top_nxt   = below_top;
    end
    if (bad) begin
      err_nxt = 1'b1;
    end
    if (in_acc) begin
      if (in_ch.last_char) begin
        // end of string clears the stack, position and error
        count_nxt = '0;
        err_nxt   = 1'b0;
        pos_nxt   = '0;
      end else if (pos_r == POS_LAST) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pos_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // low 16 bits of the position, zero padded for short counters
  assign pos_wide = {16'd0, pos_r};

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (emit) begin
      out_status_r <= bad;
      out_char_r   <= bad ? in_ch.char_code : '0;
      out_pos_r    <= bad ? pos_wide[15:0] : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.bad_char     = out_char_r;
  assign out_ch.bad_position = out_pos_r;

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, count_r <= CNT_FULL, "stack count above depth")
  `ASSERT_NEXT(a_last_clears, in_acc && in_ch.last_char,
               (count_r == '0) && (pos_r == '0) && !err_r, "end of string did not clear")
  `ASSERT_SAME(a_err_reported, $rose(err_r), out_valid_r && out_status_r,
               "error latched without a mismatch result")
  `ASSERT_SAME(a_ok_zero, out_valid_r && !out_status_r,
               (out_char_r == '0) && (out_pos_r == '0), "ok result with nonzero fields")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// drives byte strings into the bracket balance checker and checks every
// verdict against a bracket stack kept in the bench, with random idling on
// both channels, one long string with a mismatch past the low position byte
// and nests deeper than the stack
// ---------------------------------------------------------------------------

module tb;

  localparam int STACK_DEPTH   = 64;
  localparam int MAX_LENGTH    = 65536;
  localparam int RANDOM_BYTES  = 830;
  localparam int CLEAN_TAIL    = 150;
  localparam int LONG_BYTES    = 280;
  localparam int LONG_BAD_AT   = 270;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam bbc_pkg::char_t CH_LOWER_A = 8'h61;

  // one verdict as it leaves on out_ch
  typedef struct packed {
    logic           status;
    bbc_pkg::char_t bad_char;
    bbc_pkg::bpos_t bad_position;
  } verdict_t;

  // bench copy of the stack, position counter and error latch; each accepted
  // byte may queue a verdict, each result transaction is checked against the
  // oldest one
  class bracket_scoreboard;
    bbc_pkg::kind_t kinds[STACK_DEPTH];
    int             depth;
    int             position;
    bit             latched;
    verdict_t       verdict_q[$];
    int             mismatches;
    int             balanced_seen;
    int             unbalanced_seen;

    function new();
      depth           = 0;
      position        = 0;
      latched         = 1'b0;
      mismatches      = 0;
      balanced_seen   = 0;
      unbalanced_seen = 0;
    endfunction

    function void note_byte(bbc_pkg::char_t c, logic last);
      bbc_pkg::kind_t k;
      bit             opens;
      bit             closes;
      bit             fired;
      verdict_t       v;
      k      = bbc_pkg::KIND_NONE;
      opens  = 1'b0;
      closes = 1'b0;
      fired  = 1'b0;
      case (c)
        bbc_pkg::CH_LPAREN:  begin opens = 1'b1;  k = bbc_pkg::KIND_PAREN;  end
        bbc_pkg::CH_LBRACE:  begin opens = 1'b1;  k = bbc_pkg::KIND_BRACE;  end
        bbc_pkg::CH_LSQUARE: begin opens = 1'b1;  k = bbc_pkg::KIND_SQUARE; end
        bbc_pkg::CH_RPAREN:  begin closes = 1'b1; k = bbc_pkg::KIND_PAREN;  end
        bbc_pkg::CH_RBRACE:  begin closes = 1'b1; k = bbc_pkg::KIND_BRACE;  end
        bbc_pkg::CH_RSQUARE: begin closes = 1'b1; k = bbc_pkg::KIND_SQUARE; end
        default: ;
      endcase
      if (!latched && opens) begin
        // a full stack drops the push
        if (depth < STACK_DEPTH) begin
          kinds[depth] = k;
          depth++;
        end
      end else if (!latched && closes) begin
        if (depth == 0) begin
          fired = 1'b1;
        end else begin
          depth--;
          fired = (kinds[depth] != k);
        end
        if (fired) begin
          latched          = 1'b1;
          v.status         = 1'b1;
          v.bad_char       = c;
          v.bad_position   = bbc_pkg::bpos_t'(position);
          verdict_q.push_back(v);
        end
      end
      if (last) begin
        if (!latched) begin
          v = '0;
          verdict_q.push_back(v);
        end
        depth    = 0;
        position = 0;
        latched  = 1'b0;
      end else begin
        position = (position + 1 >= MAX_LENGTH) ? 0 : position + 1;
      end
    endfunction

    function void check_result(logic status, bbc_pkg::char_t bad_char,
                               bbc_pkg::bpos_t bad_position);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        $error("unexpected result: status %0d bad_char 0x%02h bad_position %0d",
               status, bad_char, bad_position);
        mismatches++;
        return;
      end
      want = verdict_q.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
      if (bad_char !== want.bad_char) begin
        $error("bad_char: expected 0x%02h, actual 0x%02h", want.bad_char, bad_char);
        mismatches++;
      end
      if (bad_position !== want.bad_position) begin
        $error("bad_position: expected %0d, actual %0d", want.bad_position, bad_position);
        mismatches++;
      end
      if (want.status) unbalanced_seen++;
      else balanced_seen++;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  bbc_in_if  in_ch ();
  bbc_out_if out_ch ();

  bracket_balance_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .MAX_LENGTH (MAX_LENGTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  bracket_scoreboard sb;

  bit tx_idle_on   = 1'b0;
  bit rx_stall_on  = 1'b0;
  int stall_left   = 0;
  int quiet_cycles = 0;
  int bytes_sent   = 0;
  int strings_sent = 0;
  int pauses       = 0;

  always #5 clk = ~clk;

  // result side back-pressure: random bursts of low ready while enabled
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (rx_stall_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(1, 12) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // transaction monitor on both channels plus the watchdog; inputs move at
  // the falling edge so everything read here is settled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_byte(in_ch.char_code, in_ch.last_char);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.status, out_ch.bad_char, out_ch.bad_position);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic bbc_pkg::char_t opener_of(bbc_pkg::kind_t k);
    case (k)
      bbc_pkg::KIND_PAREN:  return bbc_pkg::CH_LPAREN;
      bbc_pkg::KIND_BRACE:  return bbc_pkg::CH_LBRACE;
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_LSQUARE;
      default:              return bbc_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic bbc_pkg::char_t closer_of(bbc_pkg::kind_t k);
    case (k)
      bbc_pkg::KIND_PAREN:  return bbc_pkg::CH_RPAREN;
      bbc_pkg::KIND_BRACE:  return bbc_pkg::CH_RBRACE;
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_RSQUARE;
      default:              return bbc_pkg::CH_SPACE;
    endcase
  endfunction

  // spaces, letters, or any byte at all (which may itself be a bracket)
  function automatic bbc_pkg::char_t filler_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return bbc_pkg::CH_SPACE;
    if (r < 7) return bbc_pkg::char_t'(CH_LOWER_A + $urandom_range(0, 25));
    return bbc_pkg::char_t'($urandom_range(0, 255));
  endfunction

  // mostly well-nested strings with random filler, some with a fault put in,
  // some left open, a few pure noise and a few nested close to or past the stack depth
  function automatic void build_random_string(ref bbc_pkg::char_t s[$]);
    int             flavor;
    int             len;
    int             cap;
    int             n;
    int             idx;
    bit             mixed;
    bbc_pkg::kind_t k;
    bbc_pkg::kind_t open_k[$];
    s.delete();
    flavor = $urandom_range(0, 19);
    if (flavor < 3) begin
      len = $urandom_range(1, 20);
      repeat (len) s.push_back(bbc_pkg::char_t'($urandom_range(0, 255)));
    end else if (flavor == 3) begin
      n     = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 8);
      mixed = $urandom_range(0, 1);
      k     = bbc_pkg::kind_t'($urandom_range(0, 2));
      for (int i = 0; i < n; i++) begin
        if (mixed) k = bbc_pkg::kind_t'($urandom_range(0, 2));
        open_k.push_back(k);
        s.push_back(opener_of(k));
      end
      while (open_k.size() != 0) s.push_back(closer_of(open_k.pop_back()));
    end else begin
      len = $urandom_range(1, 30);
      cap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 12;
      for (int i = 0; i < len; i++) begin
        n = $urandom_range(0, 9);
        if (n < 4 && open_k.size() < cap) begin
          k = bbc_pkg::kind_t'($urandom_range(0, 2));
          open_k.push_back(k);
          s.push_back(opener_of(k));
        end else if (n < 7 && open_k.size() != 0) begin
          s.push_back(closer_of(open_k.pop_back()));
        end else begin
          s.push_back(filler_byte());
        end
      end
      if ($urandom_range(0, 3) != 0)
        while (open_k.size() != 0) s.push_back(closer_of(open_k.pop_back()));
      // fault: a byte swapped for a bracket, or a stray closer
      if ($urandom_range(0, 2) == 0) begin
        idx = $urandom_range(0, s.size() - 1);
        k   = bbc_pkg::kind_t'($urandom_range(0, 2));
        if ($urandom_range(0, 1))
          s[idx] = $urandom_range(0, 1) ? closer_of(k) : opener_of(k);
        else
          s.insert(idx, closer_of(k));
      end
    end
  endfunction

  // one byte transaction; called and returns at a falling edge
  task automatic send_byte(input bbc_pkg::char_t c, input logic last);
    int gap;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last_char <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    bytes_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_string(input bbc_pkg::char_t s[$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_byte(bbc_pkg::char_t'(t[i]), i == t.len() - 1);
  endtask

  // long string: bracket pairs every 97 bytes, letters and spaces between,
  // a closer on an empty stack at bad_at
  task automatic send_long(input int total, input int bad_at);
    bbc_pkg::char_t c;
    for (int i = 0; i < total; i++) begin
      if (i == bad_at) c = bbc_pkg::CH_RBRACE;
      else if (i % 97 == 0) c = bbc_pkg::CH_LSQUARE;
      else if (i % 97 == 1) c = bbc_pkg::CH_RSQUARE;
      else if (i % 5 == 0) c = bbc_pkg::CH_SPACE;
      else c = bbc_pkg::char_t'(CH_LOWER_A + $urandom_range(0, 25));
      send_byte(c, i == total - 1);
    end
  endtask

  // hold the byte stream until every queued verdict has come out
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    pauses++;
  endtask

  initial begin
    bbc_pkg::char_t s[$];
    int             rand_start;
    bit [1:0]       mode;
    sb              = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed strings
    send_text("()");                // balanced, ok on the last byte
    send_text(")");                 // closer on an empty stack, also the last byte
    send_text("(]x)");              // wrong kind, rest of the string ignored
    s = '{8'h00, bbc_pkg::CH_LBRACE, bbc_pkg::CH_SPACE, bbc_pkg::CH_LSQUARE, 8'hFF,
          bbc_pkg::CH_RSQUARE, bbc_pkg::CH_RBRACE};
    send_string(s);                 // byte extremes among nested brackets
    send_text("[(");                // left open at the end, still ok
    send_text("{)");                // mismatch on the last byte
    send_text(" ");                 // single space
    pause_until_drained();

    // mismatch at a position above the low byte, under result stalls
    rx_stall_on = 1'b1;
    send_long(LONG_BYTES, LONG_BAD_AT);
    pause_until_drained();

    // random strings, idling mode changed every 25 strings, clean at the end
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      if (bytes_sent - rand_start >= RANDOM_BYTES - CLEAN_TAIL) begin
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
      end else if (strings_sent % 25 == 0) begin
        mode        = 2'($urandom_range(0, 3));
        tx_idle_on  = mode[0];
        rx_stall_on = mode[1];
      end
      if (strings_sent % 40 == 39) pause_until_drained();
      build_random_string(s);
      send_string(s);
    end

    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("ran %0d strings, %0d bytes: %0d balanced, %0d with a mismatch",
             strings_sent, bytes_sent, sb.balanced_seen, sb.unbalanced_seen);
    $display("stack overflow, a long string and %0d full drains included", pauses);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
